[src/ipfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfc_pkg: shared types and constants of the image packet framer
// Holds the framing constants, the output byte phases, the register
// indexes and the byte-wise reflected CRC-32 update.
// ----------------------------------------------------------------------------
package ipfc_pkg;

  localparam int HEADER_BYTES = 15;
  localparam int CRC_BYTES    = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] TYPE_BASE = 8'h66;
  localparam logic [7:0] FLAG_BASE = 8'b0100_0000;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_TYPE_CODE     = 3'd0;
  localparam logic [2:0] REG_CALLSIGN      = 3'd1;
  localparam logic [2:0] REG_IMAGE_NUMBER  = 3'd2;
  localparam logic [2:0] REG_SEQ_COUNT     = 3'd3;
  localparam logic [2:0] REG_BLOCKS_PER_SEQ = 3'd4;
  localparam logic [2:0] REG_PAYLOAD_LEN   = 3'd5;

  // Position of the outgoing byte within the bytes caused by one word.
  typedef enum logic [4:0] {
    PH_SYNC    = 5'd0,
    PH_TYPE    = 5'd1,
    PH_CALL0   = 5'd2,
    PH_CALL1   = 5'd3,
    PH_CALL2   = 5'd4,
    PH_CALL3   = 5'd5,
    PH_IMAGE   = 5'd6,
    PH_PKT_HI  = 5'd7,
    PH_PKT_LO  = 5'd8,
    PH_SEQS    = 5'd9,
    PH_BLKS    = 5'd10,
    PH_FLAGS   = 5'd11,
    PH_LEFT    = 5'd12,
    PH_FILL0   = 5'd13,
    PH_FILL1   = 5'd14,
    PH_PAYLOAD = 5'd15,
    PH_CRC0    = 5'd16,
    PH_CRC1    = 5'd17,
    PH_CRC2    = 5'd18,
    PH_CRC3    = 5'd19
  } phase_e;

  typedef struct packed {
    logic       init;
    logic       update;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = {24'd0, c[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return (c >> 8) ^ x;
  endfunction

endpackage

[src/ipfc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfc_in_if / ipfc_out_if: valid-ready channels of the framer
// The input channel carries payload words, the output channel framed bytes.
// ----------------------------------------------------------------------------
interface ipfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] leftover_bytes;

  modport source (output valid, output payload_byte, output leftover_bytes, input ready);
  modport sink (input valid, input payload_byte, input leftover_bytes, output ready);
endinterface

interface ipfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       image_end;

  modport source (output valid, output out_byte, output packet_end, output image_end,
                  input ready);
  modport sink (input valid, input out_byte, input packet_end, input image_end,
                output ready);
endinterface

[src/ipfc_crc_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfc_crc_unit: running reflected CRC-32 register
// Restarts from all ones on request and folds in one byte per cycle while an update is requested.
// ----------------------------------------------------------------------------
module ipfc_crc_unit
  import ipfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctrl_t   ctrl_i,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.update) begin
      crc_d = crc_update(crc_q, ctrl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

[src/image_packet_framer_crc32_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_packet_framer_crc32_core: image packet framer with CRC-32 trailer
// Output: the first byte caused by a word is written to the output register
//   once the word is held; one byte leaves per cycle after that while the
//   output is not stalled, as the single output byte register paces them. A
//   word adds the header on a packet's first word and the CRC on its last.
// Reset: counters and byte position clear, the CRC restarts from all ones,
//   registers take their defaults, and no word is pending.
// ----------------------------------------------------------------------------
module image_packet_framer_crc32_core
  import ipfc_pkg::*;
#(
  parameter int PACKET_BYTES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipfc_in_if.sink       in_if,
  ipfc_out_if.source    out_if,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int MAX_LEN = PACKET_BYTES - HEADER_BYTES - CRC_BYTES;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam logic [7:0] MAX_LEN8 = 8'(MAX_LEN);

  // Configuration registers.
  logic [7:0]  type_code_q;
  logic [31:0] callsign_q;
  logic [7:0]  image_number_q;
  logic [7:0]  seq_count_q;
  logic [7:0]  blocks_q;
  logic [7:0]  payload_len_q;

  // Packet state.
  logic [15:0]      pkt_cnt_q;
  logic [7:0]       seq_idx_q;
  logic [8:0]       blk_idx_q;
  logic [POS_W-1:0] pos_q;
  logic             image_done_q;
  logic             final_q;

  // Word being framed.
  logic        busy_q;
  phase_e      phase_q;
  logic        w_trl_q;
  logic        w_final_q;
  logic [7:0]  w_byte_q;
  logic [7:0]  w_left_q;
  logic [15:0] w_pkt_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_pend_q;
  logic       out_iend_q;

  logic [7:0]       seqs_eff, blks_eff, len1, eff_len;
  logic [8:0]       half_blks, last_blk;
  logic             final_calc, fin_now, has_hdr, has_trl;
  logic             in_fire, load, emit, emit_last;
  logic [7:0]       emit_byte;
  logic [31:0]      crc_val, crc_fin;
  logic [7:0]       seq_inc;
  crc_ctrl_t        crc_ctrl;

  assign seqs_eff  = (seq_count_q == 8'd0) ? 8'd1 : seq_count_q;
  assign blks_eff  = (blocks_q == 8'd0) ? 8'd1 : blocks_q;
  assign len1      = (payload_len_q == 8'd0) ? 8'd1 : payload_len_q;
  assign eff_len   = (len1 > MAX_LEN8) ? MAX_LEN8 : len1;
  // The image holds the original blocks plus half as many recovery blocks, rounded up.
  assign half_blks = ({1'b0, blks_eff} + 9'd1) >> 1;
  assign last_blk  = {1'b0, blks_eff} + half_blks - 9'd1;

  assign final_calc = (blk_idx_q > last_blk) ||
                      ((blk_idx_q == last_blk) &&
                       (({1'b0, seq_idx_q} + 9'd1) >= {1'b0, seqs_eff}));

  assign has_hdr = (pos_q == '0);
  assign has_trl = ({1'b0, 8'(pos_q)} + 9'd1) >= {1'b0, eff_len};
  assign fin_now = has_hdr ? final_calc : final_q;
  assign seq_inc = seq_idx_q + 8'd1;

  assign emit      = busy_q && (!out_valid_q || out_if.ready);
  assign emit_last = emit && (phase_q == (w_trl_q ? PH_CRC3 : PH_PAYLOAD));

  assign in_if.ready = !busy_q || emit_last;
  assign in_fire     = in_if.valid && in_if.ready;
  // After the final packet every word is dropped.
  assign load        = in_fire && !image_done_q;

  assign crc_fin = crc_val ^ CRC_INIT;

  always_comb begin
    case (phase_q)
      PH_SYNC:    emit_byte = SYNC_BYTE;
      PH_TYPE:    emit_byte = TYPE_BASE + type_code_q;
      PH_CALL0:   emit_byte = callsign_q[31:24];
      PH_CALL1:   emit_byte = callsign_q[23:16];
      PH_CALL2:   emit_byte = callsign_q[15:8];
      PH_CALL3:   emit_byte = callsign_q[7:0];
      PH_IMAGE:   emit_byte = image_number_q;
      PH_PKT_HI:  emit_byte = w_pkt_q[15:8];
      PH_PKT_LO:  emit_byte = w_pkt_q[7:0];
      PH_SEQS:    emit_byte = seqs_eff;
      PH_BLKS:    emit_byte = blks_eff;
      PH_FLAGS:   emit_byte = FLAG_BASE | {5'd0, w_final_q, 2'd0};
      PH_LEFT:    emit_byte = w_left_q;
      PH_FILL0:   emit_byte = FILL_BYTE;
      PH_FILL1:   emit_byte = FILL_BYTE;
      PH_PAYLOAD: emit_byte = w_byte_q;
      PH_CRC0:    emit_byte = crc_fin[31:24];
      PH_CRC1:    emit_byte = crc_fin[23:16];
      PH_CRC2:    emit_byte = crc_fin[15:8];
      PH_CRC3:    emit_byte = crc_fin[7:0];
      default:    emit_byte = 8'd0;
    endcase
  end

  // The sync byte is outside the checksum; header and payload are inside it.
  always_comb begin
    crc_ctrl.init   = emit && (phase_q == PH_SYNC);
    crc_ctrl.update = emit && (phase_q != PH_SYNC) && (phase_q <= PH_PAYLOAD);
    crc_ctrl.data   = emit_byte;
  end

  ipfc_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_code_q    <= 8'd0;
      callsign_q     <= 32'd0;
      image_number_q <= 8'd0;
      seq_count_q    <= 8'd1;
      blocks_q       <= 8'd1;
      payload_len_q  <= 8'd205;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TYPE_CODE:      type_code_q    <= cfg_wdata_i[7:0];
        REG_CALLSIGN:       callsign_q     <= cfg_wdata_i;
        REG_IMAGE_NUMBER:   image_number_q <= cfg_wdata_i[7:0];
        REG_SEQ_COUNT:      seq_count_q    <= cfg_wdata_i[7:0];
        REG_BLOCKS_PER_SEQ: blocks_q       <= cfg_wdata_i[7:0];
        REG_PAYLOAD_LEN:    payload_len_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Each word taken advances the byte position, a packet's last word the packet
  // counters; the word keeps a copy of what its header and trailer need.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q    <= 16'd0;
      seq_idx_q    <= 8'd0;
      blk_idx_q    <= 9'd0;
      pos_q        <= '0;
      image_done_q <= 1'b0;
      final_q      <= 1'b0;
    end else if (load) begin
      if (has_trl) begin
        pos_q     <= '0;
        pkt_cnt_q <= pkt_cnt_q + 16'd1;
        final_q   <= 1'b0;
        if (fin_now) begin
          image_done_q <= 1'b1;
        end
        if (seq_inc >= seqs_eff) begin
          seq_idx_q <= 8'd0;
          blk_idx_q <= blk_idx_q + 9'd1;
        end else begin
          seq_idx_q <= seq_inc;
        end
      end else begin
        pos_q   <= pos_q + POS_W'(1);
        final_q <= fin_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_SYNC;
    end else if (load) begin
      busy_q  <= 1'b1;
      phase_q <= has_hdr ? PH_SYNC : PH_PAYLOAD;
    end else if (emit_last) begin
      busy_q <= 1'b0;
    end else if (emit) begin
      phase_q <= phase_e'(phase_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      w_trl_q   <= has_trl;
      w_final_q <= fin_now;
      w_byte_q  <= in_if.payload_byte;
      w_left_q  <= in_if.leftover_bytes;
      w_pkt_q   <= pkt_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_pend_q <= (phase_q == PH_CRC3);
      out_iend_q <= (phase_q == PH_CRC3) && w_final_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_byte   = out_byte_q;
  assign out_if.packet_end = out_pend_q;
  assign out_if.image_end  = out_iend_q;

  // A new word is only taken mid-work when the current word's last byte leaves.
  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && in_if.ready) |-> emit_last)
    else $error("word accepted before the previous one finished");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (phase_q <= (w_trl_q ? PH_CRC3 : PH_PAYLOAD)))
    else $error("byte phase ran past the end of the word");

  a_image_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_iend_q) |-> out_pend_q)
    else $error("image end flagged outside a packet end");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (image_done_q && !busy_q) |=> (!busy_q && image_done_q))
    else $error("framer restarted after the final packet");

  a_crc_init_on_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (phase_q == PH_SYNC)) |=> (crc_val == CRC_INIT))
    else $error("checksum not restarted at packet header");

endmodule
